// ===== rtl/core/gbl_pkg.sv =====
package gbl_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int COORD_W     = 12;
   localparam int CHAN_W      = 2;
   localparam int VSUM_W      = 10;
   localparam int ACC_W       = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int MAX_HEIGHT  = 4096;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   localparam logic [12:0] IMAGE_WIDTH_RESET   = 13'd640;
   localparam logic [12:0] IMAGE_HEIGHT_RESET  = 13'd480;
   localparam logic [2:0]  CHANNEL_COUNT_RESET = 3'd1;

   // one window column, element 0 is the oldest row, element 2 the newest
   typedef logic [2:0][SAMPLE_W-1:0] column_type;

   // classified request, front to back
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic [CHAN_W-1:0]   chan;
      logic                first_col;
      logic                row_ge1;
      logic                row_ge2;
      logic                last_col;
      logic                last_row;
      logic                frame_last;
   } item_type;

   // window snapshot handed to the result sequencer
   typedef struct packed {
      logic [2:0][VSUM_W-1:0] vsum_centre;   // rows 0,1,2 weighted 1,2,1
      logic [2:0][VSUM_W-1:0] vsum_bottom;   // rows 1,2,2 weighted 1,2,1
      logic [COORD_W-1:0]     col;
      logic [COORD_W-1:0]     row;
      logic [CHAN_W-1:0]      chan;
      logic [3:0]             mask;          // up-left, up-right, cur-left, cur-right
      logic                   frame_last;
   } snap_type;

endpackage

// ===== rtl/core/gbl_front.sv =====
module gbl_front #(
   parameter int MAX_WIDTH    = 4096,
   parameter int MAX_CHANNELS = 4,
   localparam int CNTW = $clog2(MAX_WIDTH),
   localparam int AW   = $clog2(MAX_WIDTH * MAX_CHANNELS),
   localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gbl_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [gbl_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [gbl_pkg::SAMPLE_W-1:0]          req_sample_value,
   input  logic                                  push_ready,
   output logic                                  push_valid,
   output logic [AW-1:0]                         push_addr,
   output logic [CW-1:0]                         push_wsel,
   output gbl_pkg::item_type                     push_item
);

   logic [12:0]     image_width_ff, image_width_in;
   logic [12:0]     image_height_ff, image_height_in;
   logic [2:0]      channel_count_ff, channel_count_in;
   logic [CNTW-1:0] col_ff, col_in;
   logic [11:0]     row_ff, row_in;
   logic [CW-1:0]   ch_ff, ch_in;
   logic [AW-1:0]   addr_ff, addr_in;

   logic [CNTW-1:0] col_last;
   logic [11:0]     row_last;
   logic [CW-1:0]   ch_last;
   logic            accept, csr_write;
   logic            at_ch_end, at_col_end, at_row_end;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign req_ready  = push_ready;
   assign accept     = req_valid & req_ready;
   assign push_valid = accept;

   // registers saturate into their usable range
   always_comb begin
      if (image_width_ff == '0)
         col_last = '0;
      else if (32'(image_width_ff) > MAX_WIDTH)
         col_last = CNTW'(MAX_WIDTH - 1);
      else
         col_last = CNTW'(image_width_ff - 13'd1);

      if (image_height_ff == '0)
         row_last = '0;
      else if (32'(image_height_ff) > gbl_pkg::MAX_HEIGHT)
         row_last = 12'(gbl_pkg::MAX_HEIGHT - 1);
      else
         row_last = 12'(image_height_ff - 13'd1);

      if (channel_count_ff == '0)
         ch_last = '0;
      else if (32'(channel_count_ff) > MAX_CHANNELS)
         ch_last = CW'(MAX_CHANNELS - 1);
      else
         ch_last = CW'(channel_count_ff - 3'd1);
   end

   assign at_ch_end  = (ch_ff == ch_last);
   assign at_col_end = (col_ff == col_last);
   assign at_row_end = (row_ff == row_last);

   always_comb begin
      push_addr             = addr_ff;
      push_wsel             = ch_ff;
      push_item.sample      = req_sample_value;
      push_item.col         = 12'(col_ff);
      push_item.row         = row_ff;
      push_item.chan        = 2'(ch_ff);
      push_item.first_col   = (col_ff == '0);
      push_item.row_ge1     = (row_ff != '0);
      push_item.row_ge2     = (row_ff[11:1] != '0);
      push_item.last_col    = at_col_end;
      push_item.last_row    = at_row_end;
      push_item.frame_last  = at_ch_end & at_col_end & at_row_end;
   end

   always_comb begin
      image_width_in   = image_width_ff;
      image_height_in  = image_height_ff;
      channel_count_in = channel_count_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      ch_in            = ch_ff;
      addr_in          = addr_ff;
      if (csr_write) begin
         unique case (csr_index)
            gbl_pkg::CSR_IMAGE_WIDTH: begin
               image_width_in = csr_data;
            end
            gbl_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_data;
            end
            gbl_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_in = csr_data[2:0];
            end
            default: begin
            end
         endcase
         // any known register restarts the frame
         if (csr_index == gbl_pkg::CSR_IMAGE_WIDTH || csr_index == gbl_pkg::CSR_IMAGE_HEIGHT
             || csr_index == gbl_pkg::CSR_CHANNEL_COUNT) begin
            col_in  = '0;
            row_in  = '0;
            ch_in   = '0;
            addr_in = '0;
         end
      end else if (accept) begin
         ch_in   = at_ch_end ? '0 : ch_ff + 1'b1;
         addr_in = (at_ch_end && at_col_end) ? '0 : addr_ff + 1'b1;
         if (at_ch_end) begin
            col_in = at_col_end ? '0 : col_ff + 1'b1;
            if (at_col_end) begin
               row_in = at_row_end ? '0 : row_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= gbl_pkg::IMAGE_WIDTH_RESET;
         image_height_ff  <= gbl_pkg::IMAGE_HEIGHT_RESET;
         channel_count_ff <= gbl_pkg::CHANNEL_COUNT_RESET;
         col_ff           <= '0;
         row_ff           <= '0;
         ch_ff            <= '0;
         addr_ff          <= '0;
      end else begin
         image_width_ff   <= image_width_in;
         image_height_ff  <= image_height_in;
         channel_count_ff <= channel_count_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         ch_ff            <= ch_in;
         addr_ff          <= addr_in;
      end
   end

endmodule

// ===== rtl/core/gbl_queue.sv =====
module gbl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = $clog2(DEPTH),
   localparam int NW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data,
   input  logic             head_pop
);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slots_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = head_pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slots_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== rtl/core/gbl_window.sv =====
module gbl_window #(
   parameter int MAX_WIDTH    = 4096,
   parameter int MAX_CHANNELS = 4,
   localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS,
   localparam int AW = $clog2(LINE_DEPTH),
   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  logic [AW-1:0]     head_addr,
   input  logic [CW-1:0]     head_wsel,
   input  gbl_pkg::item_type head_item,
   output logic              head_pop,
   output logic              snap_valid,
   output gbl_pkg::snap_type snap,
   input  logic              snap_ready
);

   localparam int SW = gbl_pkg::SAMPLE_W;

   // {older row, newer row} per address
   logic [2*SW-1:0]     line_mem [LINE_DEPTH];
   logic [2*SW-1:0]     rd_data_ff;
   logic [2*SW-1:0]     fwd_data_ff;
   logic                fwd_ff;

   gbl_pkg::column_type win_a_ff [MAX_CHANNELS];
   gbl_pkg::column_type win_b_ff [MAX_CHANNELS];

   logic                b1_valid_ff, b1_valid_in;
   gbl_pkg::item_type   b1_item_ff;
   logic [AW-1:0]       b1_addr_ff;
   logic [CW-1:0]       b1_wsel_ff;

   logic [SW-1:0]       older, newer;
   gbl_pkg::column_type cur, col0, col1, col2;
   logic [3:0]          mask;
   logic                has_out, commit, fwd_hit;

   function automatic logic [gbl_pkg::VSUM_W-1:0] vsum_centre(gbl_pkg::column_type c);
      return {2'b00, c[0]} + {1'b0, c[1], 1'b0} + {2'b00, c[2]};
   endfunction

   // bottom row clamped: rows 1,2,2
   function automatic logic [gbl_pkg::VSUM_W-1:0] vsum_bottom(gbl_pkg::column_type c);
      return {2'b00, c[1]} + {1'b0, c[2], 1'b0} + {2'b00, c[2]};
   endfunction

   always_comb begin
      {older, newer} = fwd_ff ? fwd_data_ff : rd_data_ff;

      // clamp at the top edge
      cur[2] = b1_item_ff.sample;
      cur[1] = b1_item_ff.row_ge1 ? newer : b1_item_ff.sample;
      cur[0] = b1_item_ff.row_ge2 ? older : cur[1];

      // clamp at the left edge
      col0 = b1_item_ff.first_col ? cur : win_a_ff[b1_wsel_ff];
      col1 = b1_item_ff.first_col ? cur : win_b_ff[b1_wsel_ff];
      col2 = cur;

      mask[0] = b1_item_ff.row_ge1  & ~b1_item_ff.first_col;
      mask[1] = b1_item_ff.row_ge1  &  b1_item_ff.last_col;
      mask[2] = b1_item_ff.last_row & ~b1_item_ff.first_col;
      mask[3] = b1_item_ff.last_row &  b1_item_ff.last_col;
      has_out = (mask != '0);

      snap.vsum_centre[0] = vsum_centre(col0);
      snap.vsum_centre[1] = vsum_centre(col1);
      snap.vsum_centre[2] = vsum_centre(col2);
      snap.vsum_bottom[0] = vsum_bottom(col0);
      snap.vsum_bottom[1] = vsum_bottom(col1);
      snap.vsum_bottom[2] = vsum_bottom(col2);
      snap.col            = b1_item_ff.col;
      snap.row            = b1_item_ff.row;
      snap.chan           = b1_item_ff.chan;
      snap.mask           = mask;
      snap.frame_last     = b1_item_ff.frame_last;

      snap_valid  = b1_valid_ff & has_out;
      commit      = b1_valid_ff & (~has_out | snap_ready);
      head_pop    = head_valid & (~b1_valid_ff | commit);
      // one-pixel rows: the read misses the write landing in the same cycle
      fwd_hit     = commit & (head_addr == b1_addr_ff);
      b1_valid_in = head_pop ? 1'b1 : (commit ? 1'b0 : b1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset)
         b1_valid_ff <= 1'b0;
      else
         b1_valid_ff <= b1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         rd_data_ff  <= line_mem[head_addr];
         b1_item_ff  <= head_item;
         b1_addr_ff  <= head_addr;
         b1_wsel_ff  <= head_wsel;
         fwd_ff      <= fwd_hit;
         fwd_data_ff <= {newer, b1_item_ff.sample};
      end
      if (commit) begin
         line_mem[b1_addr_ff] <= {newer, b1_item_ff.sample};
         win_a_ff[b1_wsel_ff] <= col1;
         win_b_ff[b1_wsel_ff] <= col2;
      end
   end

endmodule

// ===== rtl/core/gbl_emit.sv =====
module gbl_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          snap_valid,
   input  gbl_pkg::snap_type             snap,
   output logic                          snap_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gbl_pkg::SAMPLE_W-1:0]  rsp_filtered_value,
   output logic [gbl_pkg::COORD_W-1:0]   rsp_out_column,
   output logic [gbl_pkg::COORD_W-1:0]   rsp_out_row,
   output logic [gbl_pkg::CHAN_W-1:0]    rsp_out_channel,
   output logic                          rsp_run_last,
   output logic                          rsp_frame_end
);

   localparam int AC = gbl_pkg::ACC_W;

   gbl_pkg::snap_type snap_ff;
   logic [3:0]        pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [gbl_pkg::SAMPLE_W-1:0] value_ff;
   logic [gbl_pkg::COORD_W-1:0]  column_ff, row_ff;
   logic [gbl_pkg::CHAN_W-1:0]   channel_ff;
   logic              run_last_ff, frame_end_ff;

   logic [3:0]        pick, pend_rest;
   logic              sel_row, sel_col, out_free, emit, take;
   logic [2:0][gbl_pkg::VSUM_W-1:0] vs;
   logic [AC-1:0]     acc;

   always_comb begin
      // lowest pending result goes first
      if (pend_ff[0])
         pick = 4'b0001;
      else if (pend_ff[1])
         pick = 4'b0010;
      else if (pend_ff[2])
         pick = 4'b0100;
      else
         pick = 4'b1000;
      sel_row   = pick[2] | pick[3];
      sel_col   = pick[1] | pick[3];
      pend_rest = pend_ff & ~pick;

      out_free   = ~rsp_valid_ff | rsp_ready;
      emit       = (pend_ff != '0) & out_free;
      snap_ready = (pend_ff == '0) | (emit & (pend_rest == '0));
      take       = snap_valid & snap_ready;

      vs = sel_row ? snap_ff.vsum_bottom : snap_ff.vsum_centre;
      if (sel_col)   // right edge clamped: columns 1,2,2
         acc = AC'(vs[1]) + AC'({vs[2], 1'b0}) + AC'(vs[2]);
      else
         acc = AC'(vs[0]) + AC'({vs[1], 1'b0}) + AC'(vs[2]);

      if (take)
         pend_in = snap.mask;
      else if (emit)
         pend_in = pend_rest;
      else
         pend_in = pend_ff;

      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take)
         snap_ff <= snap;
      if (emit) begin
         value_ff     <= acc[AC-1:4];
         column_ff    <= sel_col ? snap_ff.col : snap_ff.col - 1'b1;
         row_ff       <= sel_row ? snap_ff.row : snap_ff.row - 1'b1;
         channel_ff   <= snap_ff.chan;
         run_last_ff  <= (pend_rest == '0);
         frame_end_ff <= (pend_rest == '0) & snap_ff.frame_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = value_ff;
   assign rsp_out_column     = column_ff;
   assign rsp_out_row        = row_ff;
   assign rsp_out_channel    = channel_ff;
   assign rsp_run_last       = run_last_ff;
   assign rsp_frame_end      = frame_end_ff;

endmodule

// ===== rtl/core/gaussian_blur_3x3_stream.sv =====
// 3x3 Gaussian blur (1-2-1 kernel, /16 truncated) over a raster stream of 8-bit
// samples with channels interleaved per pixel; frame edges are clamped.
// req_*: one sample per request, valid/ready. rsp_*: 0..4 results per request,
//   each with its pixel position and channel; run_last marks the last result of
//   a request and frame_end the bottom-right result of the frame.
// csr_*: writes image_width (0), image_height (1), channel_count (2); any such
//   write restarts the frame. Write only while no request is in flight.
// Throughput: one request per cycle while each request yields at most one result
//   and the receiver does not stall. The result sequencer forms one weighted sum
//   per cycle while the output is free, so a request with several results holds
//   the output until all are out; a 4-entry request queue between the front and
//   the line-store stage absorbs those bursts. Requests pass the queue, line-store
//   read, result sequencer and output register. Pixel results lag the input by
//   one row plus one pixel; the last column and last row flush their own results.
// Reset: position counters clear, registers go to 640 x 480, 1 channel. The line
//   stores are not cleared; row 0 never reads them.
// Receiver stall: the result is held in the output register, the pipeline backs
//   up into the queue, and req_ready drops once the queue is full.
module gaussian_blur_3x3_stream #(
   parameter int MAX_WIDTH    = 4096,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gbl_pkg::SAMPLE_W-1:0]        req_sample_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gbl_pkg::SAMPLE_W-1:0]        rsp_filtered_value,
   output logic [gbl_pkg::COORD_W-1:0]         rsp_out_column,
   output logic [gbl_pkg::COORD_W-1:0]         rsp_out_row,
   output logic [gbl_pkg::CHAN_W-1:0]          rsp_out_channel,
   output logic                                rsp_run_last,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gbl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gbl_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int AW     = $clog2(MAX_WIDTH * MAX_CHANNELS);
   localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int ITEM_W = $bits(gbl_pkg::item_type);
   localparam int QW     = AW + CW + ITEM_W;

   // front to queue
   logic              push_valid, push_ready;
   logic [AW-1:0]     push_addr;
   logic [CW-1:0]     push_wsel;
   gbl_pkg::item_type push_item;

   // queue to window stage
   logic              head_valid, head_pop;
   logic [QW-1:0]     head_data;
   logic [AW-1:0]     head_addr;
   logic [CW-1:0]     head_wsel;
   gbl_pkg::item_type head_item;

   // window stage to result sequencer
   logic              snap_valid, snap_ready;
   gbl_pkg::snap_type snap;

   assign head_addr = head_data[QW-1 -: AW];
   assign head_wsel = head_data[ITEM_W +: CW];
   assign head_item = head_data[ITEM_W-1:0];

   // configuration, position counters and request classification
   gbl_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .push_ready       (push_ready),
      .push_valid       (push_valid),
      .push_addr        (push_addr),
      .push_wsel        (push_wsel),
      .push_item        (push_item)
   );

   gbl_queue #(
      .WIDTH (QW),
      .DEPTH (gbl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_addr, push_wsel, push_item}),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop)
   );

   // line stores and per-channel 3x3 window
   gbl_window #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_addr  (head_addr),
      .head_wsel  (head_wsel),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_ready (snap_ready)
   );

   // one result per cycle into the output register while it is free
   gbl_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .snap_valid         (snap_valid),
      .snap               (snap),
      .snap_ready         (snap_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_out_column     (rsp_out_column),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_run_last       (rsp_run_last),
      .rsp_frame_end      (rsp_frame_end)
   );

endmodule
